// File: hdl/mf3_pkg.sv
// shared types and constants of the 3x3 median filter
package mf3_pkg;

	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int MAX_HEIGHT_DEF     = 4096;
	localparam int LINE_WIDTH_RESET   = 1024;
	localparam int FRAME_HEIGHT_RESET = 4096;

	localparam int SAMPLE_W       = 8;
	localparam int LINE_WIDTH_W   = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam int WIN_SIZE   = 9;
	localparam int FIFO_DEPTH = 16;

	typedef logic [SAMPLE_W-1:0] pix_t;

	typedef struct packed {
		logic req_type;
		pix_t sample;
	} mf3_in_t;

	typedef struct packed {
		pix_t median;
		logic frame_done;
	} mf3_out_t;

	typedef struct packed {
		logic valid;
		logic frame_done;
	} mf3_ctl_t;

endpackage

// File: hdl/median_filter_3x3_core.sv
// top level of the 3x3 median filter: counters, line store access, window, credits
//
// Samples enter on the in channel (in_valid/in_stall) in raster order, line_width
// per row, frame_height rows per frame; then line_width+1 drain beats
// (req_type = 1) flush the last rows. Beats of the wrong kind for the current
// phase are dropped. Medians leave on the out channel (out_valid/out_stall);
// the median of position p is produced by input beat p+line_width+1, and
// frame_done marks the last result of a frame.
// One input beat per clock is taken while in_stall is low. A result passes the
// line store read, the window shift, the window select, the median network and
// the result queue before it appears on out. This 16-entry queue decouples
// the output; in_stall rises only when the queue plus results still in the
// pipeline reach 16, so an output stall backs up into the input after that many
// results. Reset clears counters, window and queue and sets line_width and
// frame_height to 1024 and 4096; the line stores are not cleared. A configuration
// write restarts the frame.
module median_filter_3x3_core
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  mf3_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mf3_out_t               out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic lc1;  // left column is the center column
		logic rc2;  // right column is the newest column
		logic tr1;  // top row is the center row
		logic br2;  // bottom row is the newest row
	} sel_t;

	function automatic logic [31:0] clamp_u(logic [31:0] v, logic [31:0] hi);
		if (v == 32'd0) begin
			return 32'd1;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// configuration and position
	logic [CW-1:0] w_q, col_q;
	logic [RW-1:0] h_q, row_q;

	// front stage signals
	logic          acc, drain, in_frame, phase_ok, bad, step, emit, col_pos, last_row;
	logic [RW-1:0] h_p1;
	pix_t          new_sample;
	sel_t          sel_now;
	logic [CW-1:0] col_inc;

	// stage 1: line store data back
	logic          valid_s1, emit_s1, done_s1, fwd_s1;
	logic [AW-1:0] addr_s1;
	pix_t          new_s1;
	sel_t          sel_s1;
	logic [2*SAMPLE_W-1:0] fwd_data_s1, rd_data;
	pix_t          top_s1, mid_s1;

	// stage 2: window holds the item's columns
	pix_t          win_q [3][3];
	mf3_ctl_t      ctl_s2;
	sel_t          sel_s2;
	logic [1:0]    ridx [3];
	logic [1:0]    cidx [3];

	// stage 3: selected neighborhood
	mf3_ctl_t            ctl_s3;
	pix_t [WIN_SIZE-1:0] v_s3;

	logic          res_valid;
	mf3_out_t      res_data;
	logic [NW-1:0] credit_q;

	assign acc        = in_valid && !in_stall;
	assign drain      = in_data.req_type;
	assign in_frame   = (row_q < h_q);
	assign phase_ok   = in_frame ? !drain : drain;
	assign h_p1       = h_q + RW'(1);
	assign bad        = (col_q >= w_q) || (row_q > h_p1);
	assign step       = acc && phase_ok && !bad;
	assign col_pos    = (col_q != '0);
	assign last_row   = (row_q == h_p1);
	assign emit       = (row_q >= RW'(2)) || ((row_q == RW'(1)) && col_pos);
	assign new_sample = drain ? '0 : in_data.sample;
	assign col_inc    = col_q + CW'(1);

	// edge replication: at column zero the window is one column behind
	assign sel_now.lc1 = col_pos ? (col_q == CW'(1)) : (w_q == CW'(1));
	assign sel_now.rc2 = col_pos;
	assign sel_now.tr1 = col_pos ? (row_q == RW'(1)) : (row_q == RW'(2));
	assign sel_now.br2 = col_pos ? (row_q < h_q) : (row_q < h_p1);

	assign in_stall = (credit_q >= NW'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= CW'(clamp_u(32'(LINE_WIDTH_RESET), 32'(MAX_WIDTH)));
			h_q   <= RW'(clamp_u(32'(FRAME_HEIGHT_RESET), 32'(MAX_HEIGHT)));
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: begin
					w_q <= CW'(clamp_u(32'(cfg_data[LINE_WIDTH_W-1:0]), 32'(MAX_WIDTH)));
				end
				REG_FRAME_HEIGHT: begin
					h_q <= RW'(clamp_u(32'(cfg_data[FRAME_HEIGHT_W-1:0]), 32'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc && phase_ok) begin
			if (bad || last_row) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_q) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_inc;
			end
		end
	end

	mf3_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.rd_en  (step),
		.rd_addr(col_q[AW-1:0]),
		.rd_data(rd_data),
		.wr_en  (valid_s1),
		.wr_addr(addr_s1),
		.wr_data({mid_s1, new_s1})
	);

	// back-to-back hit on the entry being written: take the write data
	assign top_s1 = fwd_s1 ? fwd_data_s1[2*SAMPLE_W-1:SAMPLE_W] : rd_data[2*SAMPLE_W-1:SAMPLE_W];
	assign mid_s1 = fwd_s1 ? fwd_data_s1[SAMPLE_W-1:0] : rd_data[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
		end else begin
			valid_s1          <= step;
			ctl_s2.valid      <= valid_s1 && emit_s1;
			ctl_s2.frame_done <= done_s1;
			ctl_s3            <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			emit_s1     <= emit;
			done_s1     <= last_row;
			addr_s1     <= col_q[AW-1:0];
			new_s1      <= new_sample;
			sel_s1      <= sel_now;
			fwd_s1      <= valid_s1 && (addr_s1 == col_q[AW-1:0]);
			fwd_data_s1 <= {mid_s1, new_s1};
		end
		sel_s2 <= sel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= new_s1;
		end
	end

	always_comb begin
		ridx[0] = sel_s2.tr1 ? 2'd1 : 2'd0;
		ridx[1] = 2'd1;
		ridx[2] = sel_s2.br2 ? 2'd2 : 2'd1;
		cidx[0] = sel_s2.lc1 ? 2'd1 : 2'd0;
		cidx[1] = 2'd1;
		cidx[2] = sel_s2.rc2 ? 2'd2 : 2'd1;
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				v_s3[a*3+b] <= win_q[ridx[a]][cidx[b]];
			end
		end
	end

	mf3_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.win_ctl  (ctl_s3),
		.win_v    (v_s3),
		.res_valid(res_valid),
		.res_data (res_data)
	);

	mf3_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// results in flight plus queued, counted from the accepting beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			priority if ((step && emit) && !(out_valid && !out_stall)) begin
				credit_q <= credit_q + NW'(1);
			end else if (!(step && emit) && (out_valid && !out_stall)) begin
				credit_q <= credit_q - NW'(1);
			end
		end
	end

endmodule

// File: hdl/mf3_line_store.sv
// dual line store: one entry holds the upper and middle line samples of a column
module mf3_line_store
	import mf3_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [2*SAMPLE_W-1:0]                  rd_data,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [2*SAMPLE_W-1:0]                  wr_data
);

	logic [2*SAMPLE_W-1:0] mem [DEPTH];
	logic [2*SAMPLE_W-1:0] rd_data_q;

	// read during write returns the old entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/mf3_median.sv
// three-stage median-of-nine network: sort triples, combine, pick middle
module mf3_median
	import mf3_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  mf3_ctl_t                  win_ctl,
	input  pix_t [WIN_SIZE-1:0]       win_v,
	output logic                      res_valid,
	output mf3_out_t                  res_data
);

	function automatic pix_t min2(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(pix_t a, pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	mf3_ctl_t   ctl_s1, ctl_s2, ctl_s3;
	pix_t [2:0] lo_s1, md_s1, hi_s1;
	pix_t       lo_s2, md_s2, hi_s2;
	pix_t       med_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= win_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 3; g++) begin
			lo_s1[g] <= min2(min2(win_v[3*g], win_v[3*g+1]), win_v[3*g+2]);
			md_s1[g] <= med3(win_v[3*g], win_v[3*g+1], win_v[3*g+2]);
			hi_s1[g] <= max2(max2(win_v[3*g], win_v[3*g+1]), win_v[3*g+2]);
		end
		// largest low, middle of middles, smallest high
		lo_s2  <= max2(max2(lo_s1[0], lo_s1[1]), lo_s1[2]);
		md_s2  <= med3(md_s1[0], md_s1[1], md_s1[2]);
		hi_s2  <= min2(min2(hi_s1[0], hi_s1[1]), hi_s1[2]);
		med_s3 <= med3(lo_s2, md_s2, hi_s2);
	end

	assign res_valid           = ctl_s3.valid;
	assign res_data.median     = med_s3;
	assign res_data.frame_done = ctl_s3.frame_done;

endmodule

// File: hdl/mf3_out_fifo.sv
// result queue between the median pipeline and the output channel
module mf3_out_fifo
	import mf3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mf3_out_t push_data,
	output logic     out_valid,
	input  logic     out_stall,
	output mf3_out_t out_data
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	mf3_out_t        buf_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            pop;

	assign out_valid = (count_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the 3x3 median filter core with its own window predictor
module tb_top;
	import mf3_pkg::*;

	localparam logic BEAT_PIXEL = 1'b0;
	localparam logic BEAT_DRAIN = 1'b1;
	localparam int IDLE_SETTLE = 12;

	typedef enum int {PIX_ANY, PIX_EXTREME, PIX_CLUSTER} pix_style_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mf3_in_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	mf3_out_t out_data;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	int errors = 0;
	int items_sent = 0;

	// predictor state
	logic [LINE_WIDTH_W-1:0] lw_reg = LINE_WIDTH_W'(LINE_WIDTH_RESET);
	logic [FRAME_HEIGHT_W-1:0] fh_reg = FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
	pix_t up_store[MAX_WIDTH_DEF];
	pix_t mid_store[MAX_WIDTH_DEF];
	pix_t win[3][3] = '{default: '0};
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	mf3_out_t pending_medians[$];

	median_filter_3x3_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	// rank-four element by counting, no sort
	function automatic pix_t median_of9(input pix_t v[9]);
		int below, upto, i, j;
		for (i = 0; i < 9; i++) begin
			below = 0;
			upto = 0;
			for (j = 0; j < 9; j++) begin
				if (v[j] < v[i]) below++;
				if (v[j] <= v[i]) upto++;
			end
			if (below <= 4 && upto >= 5) return v[i];
		end
		return v[0];
	endfunction

	function automatic bit median_window_step(input mf3_in_t beat, output mf3_out_t res);
		int unsigned w, h, src_row;
		bit drain, hit;
		pix_t fresh, top, mid;
		int lc, rc, tr, br, r, a, b;
		int rsel[3], csel[3];
		pix_t nine[9];
		w = (lw_reg == 0) ? 1 : ((lw_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : lw_reg);
		h = (fh_reg == 0) ? 1 : ((fh_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : fh_reg);
		drain = (beat.req_type == BEAT_DRAIN);
		res = '0;
		hit = 1'b0;
		// wrong kind of beat for the phase is dropped
		if ((row_pos < h) == drain) return 1'b0;
		if (col_pos >= w || row_pos > h + 1) begin
			col_pos = 0;
			row_pos = 0;
			return 1'b0;
		end
		fresh = drain ? pix_t'(0) : beat.sample;
		top = up_store[col_pos];
		mid = mid_store[col_pos];
		up_store[col_pos] = mid;
		mid_store[col_pos] = fresh;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = fresh;
		if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
			// center sits one column back, or at the row end when col wrapped
			if (col_pos >= 1) begin
				src_row = row_pos - 1;
				lc = (col_pos == 1) ? 1 : 0;
				rc = 2;
			end else begin
				src_row = row_pos - 2;
				lc = (w == 1) ? 1 : 0;
				rc = 1;
			end
			tr = (src_row == 0) ? 1 : 0;
			br = (src_row + 1 >= h) ? 1 : 2;
			rsel = '{tr, 1, br};
			csel = '{lc, 1, rc};
			for (a = 0; a < 3; a++)
				for (b = 0; b < 3; b++)
					nine[a * 3 + b] = win[rsel[a]][csel[b]];
			res.median = median_of9(nine);
			res.frame_done = (row_pos == h + 1);
			hit = 1'b1;
		end
		if (row_pos == h + 1) begin
			col_pos = 0;
			row_pos = 0;
		end else begin
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
		return hit;
	endfunction

	always @(posedge clk) begin : score_results
		mf3_out_t want;
		if (cfg_we) begin
			if (cfg_index == REG_LINE_WIDTH)
				lw_reg = cfg_data[LINE_WIDTH_W-1:0];
			else if (cfg_index == REG_FRAME_HEIGHT)
				fh_reg = cfg_data[FRAME_HEIGHT_W-1:0];
			col_pos = 0;
			row_pos = 0;
		end
		if (in_valid && !in_stall) begin
			if (median_window_step(in_data, want)) pending_medians.push_back(want);
		end
		if (out_valid && !out_stall) begin
			if (pending_medians.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual median %0d done %0b",
					$time, out_data.median, out_data.frame_done);
			end else begin
				want = pending_medians.pop_front();
				if (out_data.median !== want.median || out_data.frame_done !== want.frame_done) begin
					errors++;
					$display("%0t: mismatch, expected median %0d done %0b, actual median %0d done %0b",
						$time, want.median, want.frame_done, out_data.median,
						out_data.frame_done);
				end
			end
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls
	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic send_beat(input logic kind, input pix_t value);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(4, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= mf3_in_t'{req_type: kind, sample: value};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		// dropped beats leave nothing to wait for, so let the pipeline settle
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic pix_t pick_sample(input pix_style_t style, input pix_t base);
		case (style)
			PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			PIX_CLUSTER: return base + pix_t'($urandom_range(3));
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(input int px_count, input int drain_count,
			input pix_style_t style, input int noise_pct);
		pix_t base;
		int i;
		base = pix_t'($urandom_range(252));
		for (i = 0; i < px_count; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(BEAT_DRAIN, pix_t'($urandom_range(255)));
			send_beat(BEAT_PIXEL, pick_sample(style, base));
			items_sent++;
		end
		for (i = 0; i < drain_count; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(BEAT_PIXEL, pix_t'($urandom_range(255)));
			send_beat(BEAT_DRAIN, pix_t'($urandom_range(255)));
			items_sent++;
		end
	endtask

	// reset sizes are far too large for a full frame: start one, let a write restart it
	task automatic test_reset_restart();
		send_frame(5, 0, PIX_ANY, 0);
	endtask

	task automatic test_tiny_frames();
		pix_t ramp[6];
		int i;
		// zero in both registers clamps to a single sample frame
		write_reg(REG_LINE_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		send_beat(BEAT_PIXEL, 8'hFF);
		send_beat(BEAT_DRAIN, 8'hFF);
		send_beat(BEAT_DRAIN, 8'h00);

		write_reg(REG_LINE_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 2);
		send_beat(BEAT_PIXEL, 8'h00);
		send_beat(BEAT_PIXEL, 8'hFF);
		send_beat(BEAT_DRAIN, 8'h5A);
		send_beat(BEAT_PIXEL, 8'hFF);
		send_beat(BEAT_PIXEL, 8'h00);
		send_beat(BEAT_PIXEL, 8'hFF);
		send_beat(BEAT_PIXEL, 8'h00);
		send_beat(BEAT_DRAIN, 8'h00);
		send_beat(BEAT_DRAIN, 8'hFF);
		send_beat(BEAT_PIXEL, 8'hA5);
		send_beat(BEAT_DRAIN, 8'h00);
		send_beat(BEAT_DRAIN, 8'h00);

		write_reg(REG_LINE_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 3);
		ramp = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE};
		for (i = 0; i < 6; i++) send_beat(BEAT_PIXEL, ramp[i]);
		for (i = 0; i < 3; i++) send_beat(BEAT_DRAIN, 8'h00);
	endtask

	task automatic test_register_extremes();
		// all ones: width masks to 2047 and clamps to the full line store;
		// one row and two drains give the first median, then a write restarts
		write_reg(REG_LINE_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 1);
		send_frame(MAX_WIDTH_DEF, 2, PIX_ANY, 0);
		// height above the maximum clamps; a short start cut off by the next write
		write_reg(REG_LINE_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		send_frame(16, 0, PIX_CLUSTER, 0);
	endtask

	task automatic test_input_backpressure();
		write_reg(REG_LINE_WIDTH, 8);
		write_reg(REG_FRAME_HEIGHT, 6);
		hold_len = 300;
		send_frame(48, 9, PIX_ANY, 0);
	endtask

	task automatic test_random_frames(input int budget);
		int w, h, stop_at, target;
		bit restart_needed, aborted;
		pix_style_t style;
		target = items_sent + budget;
		restart_needed = 1'b1;
		w = 1;
		h = 1;
		while (items_sent < target) begin
			if (restart_needed || $urandom_range(2) != 0) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
				h = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
				write_reg(REG_LINE_WIDTH, (w == 1 && $urandom_range(1)) ? 0 : w);
				write_reg(REG_FRAME_HEIGHT, (h == 1 && $urandom_range(1)) ? 0 : h);
			end
			style = pix_style_t'($urandom_range(2));
			// now and then a frame is cut short and restarted by the next write
			aborted = ($urandom_range(14) == 0);
			stop_at = aborted ? $urandom_range(w * h - 1) : w * h;
			send_frame(stop_at, aborted ? 0 : w + 1, style, 4);
			restart_needed = aborted;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		set_idling(28, 63);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_restart();
		test_tiny_frames();
		test_register_extremes();
		test_random_frames(100);
		set_idling(63, 28);
		test_random_frames(100);
		set_idling(0, 0);
		test_input_backpressure();
		test_random_frames(80);
		wait_idle();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
